// File: rtl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Types and constants shared by the LCS insert/delete distance unit.
// ----------------------------------------------------------------------------
package slid_pkg;

   localparam int LETTER_W   = 5;
   localparam int POS_W      = 18;
   localparam int DIST_W     = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int PAT_LOW_W  = 60;
   localparam int PAT_HIGH_W = 40;
   localparam int PAT_LEN_W  = 5;

   typedef logic [LETTER_W-1:0] letter_type;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd2;

endpackage

// File: rtl/substring_lcs_indel_distance_unit.sv
// ----------------------------------------------------------------------------
// substring_lcs_indel_distance_unit
// Insert/delete edit distance between a text window and a short pattern.
// ----------------------------------------------------------------------------
// Text letters are loaded one per request; the request that carries
// last_letter starts a backward pass that writes one row of the
// next-occurrence memory per cycle, while further requests are stalled. A
// query walks the DP cells of the pattern one after another: each cell
// reads the end-position memory and then a row of the next-occurrence
// memory, both through registered read ports. Error queries and empty
// patterns skip the DP and go straight to the result. A new request is
// taken while the previous result is still waiting at the output.
module substring_lcs_indel_distance_unit #(
   parameter int TEXT_MAX    = 131072,
   parameter int PATTERN_MAX = 20,
   parameter int ALPHABET    = 26
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [slid_pkg::LETTER_W-1:0]     req_letter,
   input  logic                              req_last_letter,
   input  logic [slid_pkg::POS_W-1:0]        req_left,
   input  logic [slid_pkg::POS_W-1:0]        req_right,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [slid_pkg::DIST_W-1:0]       rsp_distance,
   output logic                              rsp_error,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [slid_pkg::CSR_DATA_W-1:0]   csr_data
);
   import slid_pkg::*;

   localparam int VW   = $clog2(TEXT_MAX + 2);
   localparam int CW   = (VW > POS_W) ? VW : POS_W;
   localparam int SW   = $clog2(TEXT_MAX);
   localparam int RW   = $clog2(TEXT_MAX + 1);
   localparam int AW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int IW   = $clog2(PATTERN_MAX + 2);
   localparam int EW   = $clog2(PATTERN_MAX + 1);
   localparam int PW   = PAT_LOW_W + PAT_HIGH_W;

   typedef logic [ALPHABET-1:0][VW-1:0] row_type;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_BINIT  = 3'd1;
   localparam logic [2:0] S_BUILD  = 3'd2;
   localparam logic [2:0] S_QSTART = 3'd3;
   localparam logic [2:0] S_QEJ    = 3'd4;
   localparam logic [2:0] S_QPOS   = 3'd5;
   localparam logic [2:0] S_QUPD   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   // memories
   letter_type text_mem [TEXT_MAX];
   row_type    nocc_mem [TEXT_MAX + 1];
   logic [VW-1:0] ep_mem [PATTERN_MAX + 1];

   logic [2:0]            state_ff, state_in;
   logic [VW-1:0]         len_ff, len_in;
   logic                  ready_ff, ready_in;
   logic [PAT_LEN_W-1:0]  plen_ff;
   logic [PAT_LOW_W-1:0]  plow_ff;
   logic [PAT_HIGH_W-1:0] phigh_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic                  rsp_err_ff, rsp_err_in;

   row_type               row_ff, row_in;
   logic [VW-1:0]         bi_ff, bi_in;
   logic [IW-1:0]         i_ff, i_in, j_ff, j_in, m_ff, m_in, best_ff, best_in;
   logic [POS_W-1:0]      left_ff, left_in, right_ff, right_in;
   logic [VW-1:0]         leftm1_ff, leftm1_in;
   logic [VW-1:0]         ej_ff, ej_in, pos_ff, pos_in;
   logic                  err_ff, err_in;
   letter_type            x_ff, x_in;
   logic [PATTERN_MAX:0]  epv_ff, epv_in;

   // memory access controls
   logic                  ts_we, ts_re, nc_we, nc_re, ep_we, ep_re;
   logic [SW-1:0]         ts_waddr, ts_raddr;
   letter_type            ts_wdata, ts_rdata_ff;
   logic [RW-1:0]         nc_waddr, nc_raddr;
   row_type               nc_wdata, nc_rdata_ff;
   logic [EW-1:0]         ep_waddr, ep_raddr;
   logic [VW-1:0]         ep_wdata, ep_rdata_ff;
   logic                  ep_rvalid_ff, ep_rzero_ff;

   logic [VW-1:0]         none_v, ep_val, cand, newv, eff_len;
   letter_type            pat_letters [PATTERN_MAX];
   logic [PW-1:0]         pat_all;
   logic [POS_W:0]        win_len;
   logic [DIST_W+1:0]     dist_full;

   assign pat_all = {phigh_ff, plow_ff};
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
      if (LETTER_W * k + LETTER_W <= PW) begin : g_in
         assign pat_letters[k] = pat_all[LETTER_W*k +: LETTER_W];
      end else begin : g_out
         assign pat_letters[k] = '0;
      end
   end

   assign none_v    = len_ff + VW'(1);
   assign ep_val    = ep_rvalid_ff ? ep_rdata_ff : (ep_rzero_ff ? leftm1_ff : none_v);
   assign cand      = (32'(x_ff) < ALPHABET) ? nc_rdata_ff[x_ff[AW-1:0]] : none_v;
   assign newv      = (pos_ff <= len_ff && cand < ej_ff) ? cand : ej_ff;
   assign eff_len   = ready_ff ? '0 : len_ff;
   assign win_len   = {1'b0, right_ff} - {1'b0, left_ff} + (POS_W+1)'(1);
   assign dist_full = (DIST_W+2)'(m_ff) + (DIST_W+2)'(win_len) - ((DIST_W+2)'(best_ff) << 1);

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_error    = rsp_err_ff;
   assign csr_ready    = 1'b1;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dist_in  = rsp_dist_ff;
      rsp_err_in   = rsp_err_ff;
      row_in       = row_ff;
      bi_in        = bi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      m_in         = m_ff;
      best_in      = best_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      leftm1_in    = leftm1_ff;
      ej_in        = ej_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      x_in         = x_ff;
      epv_in       = epv_ff;
      ts_we = 1'b0; ts_waddr = eff_len[SW-1:0]; ts_wdata = req_letter;
      ts_re = 1'b0; ts_raddr = '0;
      nc_we = 1'b0; nc_waddr = '0; nc_wdata = row_ff;
      nc_re = 1'b0; nc_raddr = pos_ff[RW-1:0];
      ep_we = 1'b0; ep_waddr = j_ff[EW-1:0]; ep_wdata = newv;
      ep_re = 1'b0; ep_raddr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  len_in   = eff_len;
                  ready_in = 1'b0;
                  if (CW'(eff_len) < CW'(TEXT_MAX)) begin
                     ts_we  = 1'b1;
                     len_in = eff_len + VW'(1);
                  end
                  if (req_last_letter) begin
                     state_in = S_BINIT;
                  end
               end else begin
                  left_in   = req_left;
                  right_in  = req_right;
                  leftm1_in = VW'(CW'(req_left) - CW'(1));
                  epv_in    = '0;
                  best_in   = '0;
                  i_in      = IW'(1);
                  if (32'(plen_ff) > PATTERN_MAX) begin
                     m_in = IW'(PATTERN_MAX);
                  end else begin
                     m_in = IW'(plen_ff);
                  end
                  err_in = !ready_ff || req_left == '0 ||
                           CW'(req_right) > CW'(len_ff) || req_left > req_right;
                  if (err_in || m_in == '0) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_QSTART;
                  end
               end
            end
         end
         S_BINIT: begin
            for (int c = 0; c < ALPHABET; c++) begin
               row_in[c] = none_v;
            end
            nc_we    = 1'b1;
            nc_waddr = len_ff[RW-1:0];
            nc_wdata = row_in;
            bi_in    = len_ff;
            ts_re    = 1'b1;
            ts_raddr = SW'(len_ff - VW'(1));
            if (len_ff == '0) begin
               ready_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_BUILD;
            end
         end
         S_BUILD: begin
            if (32'(ts_rdata_ff) < ALPHABET) begin
               row_in[ts_rdata_ff[AW-1:0]] = bi_ff;
            end
            nc_we    = 1'b1;
            nc_waddr = RW'(bi_ff - VW'(1));
            nc_wdata = row_in;
            bi_in    = bi_ff - VW'(1);
            ts_re    = 1'b1;
            ts_raddr = SW'(bi_ff - VW'(2));
            if (bi_ff == VW'(1)) begin
               ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_QSTART: begin
            x_in     = pat_letters[i_ff - IW'(1)];
            j_in     = i_ff;
            ep_re    = 1'b1;
            ep_raddr = i_ff[EW-1:0];
            state_in = S_QEJ;
         end
         S_QEJ: begin
            ej_in    = ep_val;
            ep_re    = 1'b1;
            ep_raddr = EW'(j_ff - IW'(1));
            state_in = S_QPOS;
         end
         S_QPOS: begin
            pos_in   = ep_val;
            nc_re    = 1'b1;
            nc_raddr = ep_val[RW-1:0];
            state_in = S_QUPD;
         end
         S_QUPD: begin
            ep_we          = 1'b1;
            epv_in[j_ff[EW-1:0]] = 1'b1;
            if (CW'(newv) <= CW'(right_ff) && j_ff > best_ff) begin
               best_in = j_ff;
            end
            if (j_ff == IW'(1)) begin
               i_in = i_ff + IW'(1);
               if (i_ff == m_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_QSTART;
               end
            end else begin
               // the old lower neighbour becomes the upper cell of the next step
               ej_in    = pos_ff;
               j_in     = j_ff - IW'(1);
               ep_re    = 1'b1;
               ep_raddr = EW'(j_ff - IW'(2));
               state_in = S_QPOS;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_dist_in  = err_ff ? '0 : dist_full[DIST_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         plen_ff      <= '0;
         plow_ff      <= '0;
         phigh_ff     <= '0;
         epv_ff       <= '0;
         best_ff      <= '0;
         m_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         epv_ff       <= epv_in;
         best_ff      <= best_in;
         m_ff         <= m_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_PATTERN_LEN:  plen_ff  <= csr_data[PAT_LEN_W-1:0];
               CSR_PATTERN_LOW:  plow_ff  <= csr_data[PAT_LOW_W-1:0];
               CSR_PATTERN_HIGH: phigh_ff <= csr_data[PAT_HIGH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      rsp_err_ff  <= rsp_err_in;
      row_ff      <= row_in;
      bi_ff       <= bi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      leftm1_ff   <= leftm1_in;
      ej_ff       <= ej_in;
      pos_ff      <= pos_in;
      err_ff      <= err_in;
      x_ff        <= x_in;
   end

   always_ff @(posedge clock) begin
      if (ts_we) begin
         text_mem[ts_waddr] <= ts_wdata;
      end
      if (ts_re) begin
         ts_rdata_ff <= text_mem[ts_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (nc_we) begin
         nocc_mem[nc_waddr] <= nc_wdata;
      end
      if (nc_re) begin
         nc_rdata_ff <= nocc_mem[nc_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ep_we) begin
         ep_mem[ep_waddr] <= ep_wdata;
      end
      if (ep_re) begin
         ep_rdata_ff  <= ep_mem[ep_raddr];
         ep_rvalid_ff <= epv_ff[ep_raddr];
         ep_rzero_ff  <= (ep_raddr == '0);
      end
   end

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      best_ff <= m_ff) else $error("LCS length exceeds pattern length");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_dist_ff == '0)
      else $error("error result carries a distance");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == S_IDLE) else $error("request taken while busy");

   a_build_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BUILD && bi_ff == VW'(1) |=> ready_ff)
      else $error("table not marked ready after build");

endmodule
